// ===== src/bcpa_pkg.sv =====
// shared types and constants of the chunk pool allocator
`default_nettype none
package bcpa_pkg;
    localparam int BLOCK_COUNT      = 8;
    localparam int CHUNKS_PER_BLOCK = 8;
    localparam int CHUNK_BYTES      = 512;
    localparam int NUM_HANDLES      = 64;
    localparam int BLK_W            = 3;
    localparam int CHK_W            = 3;
    localparam int HND_W            = 6;
    localparam int CNT_W            = 7;
    localparam int OFF_W            = 16;
    localparam int LOC_W            = BLK_W + CHK_W;

    typedef enum logic [1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_FREE    = 2'd1,
        FUNC_RESERVE = 2'd2,
        FUNC_NOP     = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_CHUNK = 2'd1,
        ST_NO_HANDLE = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic latch;
        logic read;
        logic exec;
    } ctrl_t;
endpackage
`default_nettype wire

// ===== src/bcpa_ctrl.sv =====
// controller state machine of the chunk pool allocator
`default_nettype none
module bcpa_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output bcpa_pkg::ctrl_t     ctrl,
    output logic                busy
);
    bcpa_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bcpa_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bcpa_pkg::S_IDLE: if (start) state_next = bcpa_pkg::S_READ;
            bcpa_pkg::S_READ: state_next = bcpa_pkg::S_EXEC;
            bcpa_pkg::S_EXEC: state_next = bcpa_pkg::S_IDLE;
            default:          state_next = bcpa_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl.latch = (state_reg == bcpa_pkg::S_IDLE) && start;
        ctrl.read  = (state_reg == bcpa_pkg::S_READ);
        ctrl.exec  = (state_reg == bcpa_pkg::S_EXEC);
        busy       = (state_reg != bcpa_pkg::S_IDLE);
    end
endmodule
`default_nettype wire

// ===== src/bcpa_dp.sv =====
// datapath: bitmaps, handle tables and free stack
`default_nettype none
module bcpa_dp (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire bcpa_pkg::ctrl_t             ctrl,
    input  wire logic [1:0]                  func,
    input  wire logic [bcpa_pkg::HND_W-1:0]  handle,
    input  wire logic [bcpa_pkg::OFF_W-1:0]  size,
    output logic                             done,
    output logic [1:0]                       status,
    output logic [bcpa_pkg::HND_W-1:0]       handle_out,
    output logic [bcpa_pkg::BLK_W-1:0]       blk_id,
    output logic [bcpa_pkg::CHK_W-1:0]       chk_id,
    output logic [bcpa_pkg::OFF_W-1:0]       offset,
    output logic                             is_external
);
    logic [bcpa_pkg::CHUNKS_PER_BLOCK-1:0] bitmap_reg [bcpa_pkg::BLOCK_COUNT];
    logic [bcpa_pkg::NUM_HANDLES-1:0]      busy_reg;
    logic [bcpa_pkg::CNT_W-1:0]            count_reg;
    // bottom part of the stack is the reset image until first overwritten
    logic [bcpa_pkg::CNT_W-1:0]            init_reg;

    logic [bcpa_pkg::LOC_W-1:0]  loc_mem   [bcpa_pkg::NUM_HANDLES];
    logic [bcpa_pkg::OFF_W-1:0]  off_mem   [bcpa_pkg::NUM_HANDLES];
    logic                        spill_mem [bcpa_pkg::NUM_HANDLES];
    logic [bcpa_pkg::HND_W-1:0]  stack_mem [bcpa_pkg::NUM_HANDLES];

    logic [1:0]                  func_reg;
    logic [bcpa_pkg::HND_W-1:0]  handle_reg;
    logic [bcpa_pkg::OFF_W-1:0]  size_reg;
    logic [bcpa_pkg::LOC_W-1:0]  loc_rd_reg;
    logic [bcpa_pkg::OFF_W-1:0]  off_rd_reg;
    logic                        spill_rd_reg;
    logic [bcpa_pkg::HND_W-1:0]  stack_rd_reg;
    logic [bcpa_pkg::HND_W-1:0]  top_idx;

    logic                        done_reg;
    logic [1:0]                  status_reg;
    logic [bcpa_pkg::HND_W-1:0]  hout_reg;
    logic [bcpa_pkg::BLK_W-1:0]  blk_reg;
    logic [bcpa_pkg::CHK_W-1:0]  chk_reg;
    logic [bcpa_pkg::OFF_W-1:0]  off_reg;
    logic                        ext_reg;

    logic [1:0]                  status_next;
    logic [bcpa_pkg::HND_W-1:0]  hout_next;
    logic [bcpa_pkg::BLK_W-1:0]  blk_next;
    logic [bcpa_pkg::CHK_W-1:0]  chk_next;
    logic [bcpa_pkg::OFF_W-1:0]  off_next;
    logic                        ext_next;

    assign top_idx = bcpa_pkg::HND_W'(count_reg - 1'b1);

    // input capture
    always_ff @(posedge clk)
    begin
        if (ctrl.latch)
        begin
            func_reg   <= func;
            handle_reg <= handle;
            size_reg   <= size;
        end
    end

    // table reads, in the cycle after input capture
    always_ff @(posedge clk)
    begin
        if (ctrl.read)
        begin
            loc_rd_reg   <= loc_mem[handle_reg];
            off_rd_reg   <= off_mem[handle_reg];
            spill_rd_reg <= spill_mem[handle_reg];
            stack_rd_reg <= stack_mem[top_idx];
        end
    end

    // first non-full block and lowest free chunk
    logic                         any_free;
    logic [bcpa_pkg::BLK_W-1:0]   free_blk;
    logic [bcpa_pkg::CHK_W-1:0]   free_chk;
    always_comb
    begin
        any_free = 1'b0;
        free_blk = '0;
        for (int b = bcpa_pkg::BLOCK_COUNT - 1; b >= 0; b--)
            if (!(&bitmap_reg[b]))
            begin
                any_free = 1'b1;
                free_blk = bcpa_pkg::BLK_W'(b);
            end
        free_chk = '0;
        for (int c = bcpa_pkg::CHUNKS_PER_BLOCK - 1; c >= 0; c--)
            if (!bitmap_reg[free_blk][c])
                free_chk = bcpa_pkg::CHK_W'(c);
    end

    logic [bcpa_pkg::HND_W-1:0]  pop_h;
    logic [bcpa_pkg::OFF_W:0]    rs;
    logic [bcpa_pkg::OFF_W+1:0]  nw;
    logic [bcpa_pkg::BLK_W-1:0]  own_blk;
    logic [bcpa_pkg::CHK_W-1:0]  own_chk;
    logic                        valid_h;
    logic                        spill_now;

    always_comb
    begin
        // reset image holds handle 63 - i at slot i, so handle 0 is on top
        pop_h = (count_reg <= init_reg) ? ~top_idx : stack_rd_reg;
        rs = {1'b0, size_reg} + {{bcpa_pkg::OFF_W{1'b0}}, size_reg[0]};
        nw = {2'b00, off_rd_reg} + {1'b0, rs};
        own_blk = loc_rd_reg[bcpa_pkg::LOC_W-1:bcpa_pkg::CHK_W];
        own_chk = loc_rd_reg[bcpa_pkg::CHK_W-1:0];
        valid_h = busy_reg[handle_reg];
        spill_now = (nw >= (bcpa_pkg::OFF_W+2)'(bcpa_pkg::CHUNK_BYTES)) && !spill_rd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < bcpa_pkg::BLOCK_COUNT; b++)
                bitmap_reg[b] <= '0;
            busy_reg  <= '0;
            count_reg <= bcpa_pkg::CNT_W'(bcpa_pkg::NUM_HANDLES);
            init_reg  <= bcpa_pkg::CNT_W'(bcpa_pkg::NUM_HANDLES);
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.exec;
            if (ctrl.exec)
            begin
                unique case (func_reg)
                    bcpa_pkg::FUNC_ALLOC:
                        if (any_free && count_reg != '0)
                        begin
                            bitmap_reg[free_blk][free_chk] <= 1'b1;
                            count_reg <= count_reg - 1'b1;
                            busy_reg[pop_h] <= 1'b1;
                        end
                    bcpa_pkg::FUNC_FREE:
                        if (valid_h)
                        begin
                            if (!spill_rd_reg)
                                bitmap_reg[own_blk][own_chk] <= 1'b0;
                            busy_reg[handle_reg] <= 1'b0;
                            if (count_reg < init_reg)
                                init_reg <= count_reg;
                            count_reg <= count_reg + 1'b1;
                        end
                    bcpa_pkg::FUNC_RESERVE:
                        if (valid_h && spill_now)
                            bitmap_reg[own_blk][own_chk] <= 1'b0;
                    default: ;
                endcase
            end
        end
    end

    // table writes
    always_ff @(posedge clk)
    begin
        if (ctrl.exec)
        begin
            if (func_reg == bcpa_pkg::FUNC_ALLOC && any_free && count_reg != '0)
            begin
                loc_mem[pop_h]   <= {free_blk, free_chk};
                off_mem[pop_h]   <= '0;
                spill_mem[pop_h] <= 1'b0;
            end
            else if (func_reg == bcpa_pkg::FUNC_FREE && valid_h)
                stack_mem[bcpa_pkg::HND_W'(count_reg)] <= handle_reg;
            else if (func_reg == bcpa_pkg::FUNC_RESERVE && valid_h)
            begin
                off_mem[handle_reg] <= nw[bcpa_pkg::OFF_W+1:bcpa_pkg::OFF_W] != 2'b00
                                       ? '1 : nw[bcpa_pkg::OFF_W-1:0];
                if (spill_now)
                    spill_mem[handle_reg] <= 1'b1;
            end
        end
    end

    // result fields
    always_comb
    begin
        status_next = bcpa_pkg::ST_OK;
        hout_next   = handle_reg;
        blk_next    = '0;
        chk_next    = '0;
        off_next    = '0;
        ext_next    = 1'b0;
        unique case (func_reg)
            bcpa_pkg::FUNC_ALLOC:
            begin
                hout_next = '0;
                if (!any_free)
                    status_next = bcpa_pkg::ST_NO_CHUNK;
                else if (count_reg == '0)
                    status_next = bcpa_pkg::ST_NO_HANDLE;
                else
                begin
                    hout_next = pop_h;
                    blk_next  = free_blk;
                    chk_next  = free_chk;
                end
            end
            bcpa_pkg::FUNC_FREE, bcpa_pkg::FUNC_RESERVE:
                if (!valid_h)
                    status_next = bcpa_pkg::ST_NO_HANDLE;
                else
                begin
                    blk_next = own_blk;
                    chk_next = own_chk;
                    if (func_reg == bcpa_pkg::FUNC_FREE)
                        ext_next = spill_rd_reg;
                    else
                    begin
                        off_next = off_rd_reg;
                        ext_next = spill_rd_reg | spill_now;
                        if (nw[bcpa_pkg::OFF_W+1:bcpa_pkg::OFF_W] != 2'b00)
                            status_next = bcpa_pkg::ST_OVERFLOW;
                    end
                end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (ctrl.exec)
        begin
            status_reg <= status_next;
            hout_reg   <= hout_next;
            blk_reg    <= blk_next;
            chk_reg    <= chk_next;
            off_reg    <= off_next;
            ext_reg    <= ext_next;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign handle_out  = hout_reg;
    assign blk_id      = blk_reg;
    assign chk_id      = chk_reg;
    assign offset      = off_reg;
    assign is_external = ext_reg;
endmodule
`default_nettype wire

// ===== src/bitmap_chunk_pool_allocator.sv =====
// top level of the bitmap chunk pool allocator
//
// command channel: a transfer happens at a rising edge with start high and
// busy low; func selects alloc, free, reserve (3 is a no-op), handle and
// size are sampled at that edge.
// result channel: done pulses for one cycle with status, handle_out,
// blk_id, chk_id, offset and is_external valid in that cycle.
// the receiver cannot stall; every command yields exactly one result.
// timing: after the command edge the handle tables and free stack are read
// into registers, then the read-modify-write executes into the output
// register and done rises; busy stays high through the read and execute
// states, so a new command is taken only after the previous one has
// executed.
// reset: all chunks free, all 64 handles on the free stack (handle 0 on
// top); handle tables need no clearing since unallocated handles are
// rejected through per-handle busy bits.
`default_nettype none
module bitmap_chunk_pool_allocator (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  func,
    input  wire logic [bcpa_pkg::HND_W-1:0]  handle,
    input  wire logic [bcpa_pkg::OFF_W-1:0]  size,
    output logic                             done,
    output logic [1:0]                       status,
    output logic [bcpa_pkg::HND_W-1:0]       handle_out,
    output logic [bcpa_pkg::BLK_W-1:0]       blk_id,
    output logic [bcpa_pkg::CHK_W-1:0]       chk_id,
    output logic [bcpa_pkg::OFF_W-1:0]       offset,
    output logic                             is_external
);
    bcpa_pkg::ctrl_t ctrl;

    bcpa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    bcpa_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .func        (func),
        .handle      (handle),
        .size        (size),
        .done        (done),
        .status      (status),
        .handle_out  (handle_out),
        .blk_id      (blk_id),
        .chk_id      (chk_id),
        .offset      (offset),
        .is_external (is_external)
    );
endmodule
`default_nettype wire
